@@ rtl/csem_pkg.sv @@
// csem_pkg: shared types and codes for the counting semaphore table
// no dependencies; imported by every module of the block
package csem_pkg;

  localparam int FUNC_W = 2;
  localparam int KEY_W  = 8;
  localparam int PROC_W = 5;
  localparam int VAL_W  = 16;

  localparam int QUEUE_DEPTH = 2;

  // raw request codes as they arrive on the func field
  localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EXISTS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [KEY_W-1:0]        sem_key;
    logic [PROC_W-1:0]       proc_id;
    logic signed [VAL_W-1:0] init_limit;
    logic signed [VAL_W-1:0] init_count;
  } req_t;

  typedef struct packed {
    status_e                 status;
    logic                    block_caller;
    logic                    wake_valid;
    logic [PROC_W-1:0]       wake_proc;
    logic signed [VAL_W-1:0] count_after;
  } rsp_t;

  // classified request, proc id already reduced into range
  typedef struct packed {
    op_e                     op;
    logic [KEY_W-1:0]        sem_key;
    logic [PROC_W-1:0]       pid;
    logic signed [VAL_W-1:0] limit;
    logic signed [VAL_W-1:0] count;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } qport_t;

endpackage

@@ rtl/counting_semaphore_table_core.sv @@
// Counting semaphore table. A request is taken when start is high and busy is
// low; a two-entry queue behind the front end lets up to two requests wait
// while one is carried out, and busy rises only when that queue is full. Each
// request gives exactly one result, shown on rsp_o for a single cycle while
// done_o is high; the receiver cannot stall it. A request with an unused func
// code skips the key search; any other request runs it. The key search reads
// one table entry per cycle from the entry memory in index order and stops at
// the first match. A signal that wakes a waiter while a second one is queued
// also reads the wait-queue link memory before its result is given.
// depends on csem_pkg, csem_front, csem_queue, csem_back
module counting_semaphore_table_core #(
  parameter int NUM_SEMAPHORES = 8,
  parameter int NUM_PROCS      = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  csem_pkg::req_t req_i,
  output logic           done_o,
  output csem_pkg::rsp_t rsp_o
);
  import csem_pkg::*;

  qport_t push;
  qport_t head;
  logic   q_full;
  logic   pop;

  assign busy = q_full;

  csem_front #(
    .NUM_PROCS (NUM_PROCS)
  ) u_front (
    .start_i  (start),
    .q_full_i (q_full),
    .req_i    (req_i),
    .push_o   (push)
  );

  csem_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  csem_back #(
    .NUM_SEMAPHORES (NUM_SEMAPHORES),
    .NUM_PROCS      (NUM_PROCS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (head),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

@@ rtl/csem_front.sv @@
// csem_front: accepts requests, decodes the request kind and folds the proc id
// depends on csem_pkg
module csem_front #(
  parameter int NUM_PROCS = 32
) (
  input  logic            start_i,
  input  logic            q_full_i,
  input  csem_pkg::req_t  req_i,
  output csem_pkg::qport_t push_o
);
  import csem_pkg::*;

  localparam int PID_VALS = 2 ** PROC_W;

  logic [PROC_W-1:0] pid_tab [PID_VALS];
  op_e               op;

  // proc id modulo process count, as a constant table
  for (genvar v = 0; v < PID_VALS; v++) begin : g_pid
    assign pid_tab[v] = PROC_W'(v % NUM_PROCS);
  end

  always_comb begin
    unique case (req_i.func)
      FUNC_INIT:   op = OP_INIT;
      FUNC_WAIT:   op = OP_WAIT;
      FUNC_SIGNAL: op = OP_SIGNAL;
      default:     op = OP_NONE;
    endcase
  end

  always_comb begin
    push_o.valid        = start_i && !q_full_i;
    push_o.item.op      = op;
    push_o.item.sem_key = req_i.sem_key;
    push_o.item.pid     = pid_tab[req_i.proc_id];
    push_o.item.limit   = req_i.init_limit;
    push_o.item.count   = req_i.init_count;
  end

endmodule

@@ rtl/csem_queue.sv @@
// csem_queue: short request queue between the front end and the execution unit
// depends on csem_pkg
module csem_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csem_pkg::qport_t  push_i,
  input  logic              pop_i,
  output logic              full_o,
  output csem_pkg::qport_t  head_o
);
  import csem_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  work_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o      = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.item;
    end
  end

endmodule

@@ rtl/csem_back.sv @@
// csem_back: entry scan, semaphore update and wait-queue links
// depends on csem_pkg; fed by csem_queue
module csem_back #(
  parameter int NUM_SEMAPHORES = 8,
  parameter int NUM_PROCS      = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csem_pkg::qport_t  q_i,
  output logic              pop_o,
  output logic              done_o,
  output csem_pkg::rsp_t    rsp_o
);
  import csem_pkg::*;

  localparam int SW = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int PW = $clog2(NUM_PROCS);
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SEMAPHORES - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] limit;
    logic [VAL_W-1:0] count;
    logic [PW-1:0]    head;
    logic [PW-1:0]    tail;
  } ent_t;

  ent_t                      ent_mem [NUM_SEMAPHORES];
  ent_t                      ent_rd_q;
  logic [PW-1:0]             nw_mem [NUM_PROCS];
  logic [PW-1:0]             nw_rd_q;

  logic [1:0]                state_q, state_d;
  work_t                     wk_q, wk_d;
  logic [SW-1:0]             sidx_q, sidx_d;
  logic                      chk_vld_q, chk_vld_d;
  logic [SW-1:0]             chk_idx_q, chk_idx_d;
  logic                      free_vld_q, free_vld_d;
  logic [SW-1:0]             free_idx_q, free_idx_d;
  logic                      hit_q, hit_d;
  logic [SW-1:0]             hit_idx_q, hit_idx_d;
  ent_t                      rec_q, rec_d;
  logic [NUM_SEMAPHORES-1:0] valid_q, valid_d;
  logic [NUM_SEMAPHORES-1:0] nonempty_q, nonempty_d;
  logic                      done_q, done_d;
  rsp_t                      rsp_q, rsp_d;

  logic                      ent_re, ent_we;
  logic [SW-1:0]             ent_widx;
  ent_t                      ent_wdata;
  logic                      nw_re, nw_we;
  logic [PW-1:0]             nw_raddr, nw_waddr, nw_wdata;
  ent_t                      rec_new;
  logic [VAL_W-1:0]          new_cnt;
  logic                      blk;
  logic [PW-1:0]             pid_w;

  assign pid_w  = PW'(wk_q.pid);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    state_d    = state_q;
    wk_d       = wk_q;
    sidx_d     = sidx_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    rec_d      = rec_q;
    valid_d    = valid_q;
    nonempty_d = nonempty_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    pop_o      = 1'b0;
    ent_re     = 1'b0;
    ent_we     = 1'b0;
    ent_widx   = hit_idx_q;
    ent_wdata  = rec_q;
    nw_re      = 1'b0;
    nw_we      = 1'b0;
    nw_raddr   = rec_q.head;
    nw_waddr   = rec_q.tail;
    nw_wdata   = pid_w;
    rec_new    = rec_q;
    new_cnt    = '0;
    blk        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o      = 1'b1;
          wk_d       = q_i.item;
          sidx_d     = '0;
          free_vld_d = 1'b0;
          hit_d      = 1'b0;
          state_d    = (q_i.item.op == OP_NONE) ? S_EXEC : S_SCAN;
        end
      end

      S_SCAN: begin
        // one entry read per cycle, checked the cycle after
        ent_re    = 1'b1;
        chk_vld_d = 1'b1;
        chk_idx_d = sidx_q;
        if (sidx_q != LAST_IDX) begin
          sidx_d = sidx_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (!valid_q[chk_idx_q] && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (valid_q[chk_idx_q] && (ent_rd_q.key == wk_q.sem_key)) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            rec_d     = ent_rd_q;
            state_d   = S_EXEC;
          end else if (chk_idx_q == LAST_IDX) begin
            state_d = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        rsp_d   = '0;
        done_d  = 1'b1;
        state_d = S_IDLE;
        unique case (wk_q.op)
          OP_INIT: begin
            if (hit_q) begin
              rsp_d.status      = ST_EXISTS;
              rsp_d.count_after = rec_q.count;
            end else if (free_vld_q) begin
              ent_we                 = 1'b1;
              ent_widx               = free_idx_q;
              ent_wdata.key          = wk_q.sem_key;
              ent_wdata.limit        = wk_q.limit;
              ent_wdata.count        = wk_q.count;
              ent_wdata.head         = '0;
              ent_wdata.tail         = '0;
              valid_d[free_idx_q]    = 1'b1;
              nonempty_d[free_idx_q] = 1'b0;
              rsp_d.status           = ST_OK;
              rsp_d.count_after      = wk_q.count;
            end else begin
              rsp_d.status = ST_FULL;
            end
          end

          OP_WAIT: begin
            if (!hit_q) begin
              rsp_d.status = ST_NOTFOUND;
            end else begin
              new_cnt       = rec_q.count - 1'b1;
              blk           = ($signed(new_cnt) <= $signed(rec_q.limit));
              rec_new.count = new_cnt;
              if (blk) begin
                if (nonempty_q[hit_idx_q]) begin
                  // link the new waiter behind the old tail
                  nw_we        = 1'b1;
                  nw_waddr     = rec_q.tail;
                  rec_new.tail = pid_w;
                end else begin
                  rec_new.head          = pid_w;
                  rec_new.tail          = pid_w;
                  nonempty_d[hit_idx_q] = 1'b1;
                end
              end
              ent_we             = 1'b1;
              ent_wdata          = rec_new;
              rsp_d.status       = ST_OK;
              rsp_d.block_caller = blk;
              rsp_d.count_after  = new_cnt;
            end
          end

          OP_SIGNAL: begin
            if (!hit_q) begin
              rsp_d.status = ST_NOTFOUND;
            end else begin
              new_cnt           = rec_q.count + 1'b1;
              rec_new.count     = new_cnt;
              rsp_d.status      = ST_OK;
              rsp_d.count_after = new_cnt;
              if (nonempty_q[hit_idx_q]) begin
                rsp_d.wake_valid = 1'b1;
                rsp_d.wake_proc  = PROC_W'(rec_q.head);
              end
              if (nonempty_q[hit_idx_q] && (rec_q.head != rec_q.tail)) begin
                // successor of the head comes from the link memory
                nw_re    = 1'b1;
                nw_raddr = rec_q.head;
                rec_d    = rec_new;
                done_d   = 1'b0;
                state_d  = S_LINK;
              end else begin
                if (nonempty_q[hit_idx_q]) begin
                  nonempty_d[hit_idx_q] = 1'b0;
                end
                ent_we    = 1'b1;
                ent_wdata = rec_new;
              end
            end
          end

          OP_NONE: begin
            rsp_d = '0;
          end

          default: begin
            rsp_d = '0;
          end
        endcase
      end

      S_LINK: begin
        rec_new.head = nw_rd_q;
        ent_we       = 1'b1;
        ent_wdata    = rec_new;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      hit_q      <= 1'b0;
      valid_q    <= '0;
      nonempty_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
      hit_q      <= hit_d;
      valid_q    <= valid_d;
      nonempty_q <= nonempty_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q       <= wk_d;
    sidx_q     <= sidx_d;
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    hit_idx_q  <= hit_idx_d;
    rec_q      <= rec_d;
    rsp_q      <= rsp_d;
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_widx] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[sidx_q];
    end
  end

  // wait-queue links, one per process
  always_ff @(posedge clk_i) begin
    if (nw_we) begin
      nw_mem[nw_waddr] <= nw_wdata;
    end
    if (nw_re) begin
      nw_rd_q <= nw_mem[nw_raddr];
    end
  end

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("back end issued results on consecutive cycles");

  a_wake_block_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(rsp_q.wake_valid && rsp_q.block_caller))
    else $error("wake and block reported for the same request");

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && rsp_q.wake_valid) |-> (rsp_q.status == ST_OK))
    else $error("wake reported with an error status");

  a_queue_on_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nonempty_q & ~valid_q) == '0)
    else $error("wait queue marked busy on an unused entry");

  a_full_all_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (rsp_q.status == ST_FULL)) |-> (&valid_q))
    else $error("table full reported with a free entry");

endmodule

@@ test/csem_checker.sv @@
`timescale 1ns / 100ps
// csem_checker: watches the request and result channels of the semaphore table,
// keeps its own copy of the table and wait queues, and compares every result
// depends on csem_pkg
module csem_checker #(
  parameter int NUM_SEMAPHORES = 8,
  parameter int NUM_PROCS      = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  csem_pkg::req_t req_i,
  input  logic           done_i,
  input  csem_pkg::rsp_t rsp_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import csem_pkg::*;

  logic                    sem_used        [NUM_SEMAPHORES];
  logic [KEY_W-1:0]        sem_key         [NUM_SEMAPHORES];
  logic signed [VAL_W-1:0] sem_limit       [NUM_SEMAPHORES];
  logic signed [VAL_W-1:0] sem_count       [NUM_SEMAPHORES];
  logic                    waiters_present [NUM_SEMAPHORES];
  logic [PROC_W-1:0]       waiter_head     [NUM_SEMAPHORES];
  logic [PROC_W-1:0]       waiter_tail     [NUM_SEMAPHORES];
  logic [PROC_W-1:0]       waiter_link     [NUM_PROCS];

  rsp_t outstanding_rsp [$];

  function automatic int find_entry(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < NUM_SEMAPHORES; i++) begin
      if (sem_used[i] && sem_key[i] == key) return i;
    end
    return -1;
  endfunction

  // carries out one request on the shadow table and returns its result
  function automatic rsp_t apply_request(input req_t r);
    rsp_t              o;
    int                e;
    int                i;
    logic [PROC_W-1:0] pid;
    logic [PROC_W-1:0] h;
    o   = '0;
    pid = PROC_W'(r.proc_id % NUM_PROCS);
    e   = find_entry(r.sem_key);
    case (r.func)
      FUNC_INIT: begin
        if (e >= 0) begin
          o.status      = ST_EXISTS;
          o.count_after = sem_count[e];
        end else begin
          for (i = NUM_SEMAPHORES - 1; i >= 0; i--) begin
            if (!sem_used[i]) e = i;
          end
          if (e < 0) begin
            o.status = ST_FULL;
          end else begin
            sem_used[e]        = 1'b1;
            sem_key[e]         = r.sem_key;
            sem_limit[e]       = r.init_limit;
            sem_count[e]       = r.init_count;
            waiters_present[e] = 1'b0;
            o.count_after      = r.init_count;
          end
        end
      end
      FUNC_WAIT: begin
        if (e < 0) begin
          o.status = ST_NOTFOUND;
        end else begin
          sem_count[e] = sem_count[e] - 16'sd1;
          if (sem_count[e] <= sem_limit[e]) begin
            if (waiters_present[e]) begin
              waiter_link[waiter_tail[e] % NUM_PROCS] = pid;
            end else begin
              waiter_head[e]     = pid;
              waiters_present[e] = 1'b1;
            end
            waiter_tail[e] = pid;
            o.block_caller = 1'b1;
          end
          o.count_after = sem_count[e];
        end
      end
      FUNC_SIGNAL: begin
        if (e < 0) begin
          o.status = ST_NOTFOUND;
        end else begin
          sem_count[e] = sem_count[e] + 16'sd1;
          if (waiters_present[e]) begin
            h            = PROC_W'(waiter_head[e] % NUM_PROCS);
            o.wake_valid = 1'b1;
            o.wake_proc  = h;
            // head equal to tail means the last waiter just left
            if (h == waiter_tail[e] % NUM_PROCS) waiters_present[e] = 1'b0;
            else waiter_head[e] = waiter_link[h];
          end
          o.count_after = sem_count[e];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    int   i;
    if (!rst_ni) begin
      for (i = 0; i < NUM_SEMAPHORES; i++) begin
        sem_used[i]        = 1'b0;
        sem_key[i]         = '0;
        sem_limit[i]       = '0;
        sem_count[i]       = '0;
        waiters_present[i] = 1'b0;
      end
      outstanding_rsp.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // a result always belongs to an older request than one taken at this edge
      if (done_i) begin
        if (outstanding_rsp.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, rsp_i);
          fail_count_o++;
        end else begin
          want = outstanding_rsp.pop_front();
          compare_field("status", want.status, rsp_i.status);
          compare_field("block_caller", want.block_caller, rsp_i.block_caller);
          compare_field("wake_valid", want.wake_valid, rsp_i.wake_valid);
          compare_field("wake_proc", want.wake_proc, rsp_i.wake_proc);
          compare_field("count_after", want.count_after, rsp_i.count_after);
        end
      end
      if (start_i && !busy_i) outstanding_rsp.push_back(apply_request(req_i));
      pending_o = outstanding_rsp.size();
    end
  end

endmodule

@@ test/tb_counting_semaphore_table_core.sv @@
`timescale 1ns / 100ps
// tb_counting_semaphore_table_core: drives semaphore requests into the table
// and gives the verdict; depends on csem_pkg, counting_semaphore_table_core, csem_checker
module tb_counting_semaphore_table_core;
  import csem_pkg::*;

  localparam int NUM_SEMAPHORES = 8;
  localparam int NUM_PROCS      = 32;
  localparam int RANDOM_ITEMS   = 600;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int TAIL_CYCLES    = 4 * (NUM_SEMAPHORES + 4);

  localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  req_t        req    = '0;
  logic        done;
  rsp_t        rsp;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 8;
  int unsigned sent        = 0;

  logic [KEY_W-1:0]  key_pool   [NUM_SEMAPHORES];
  logic [PROC_W-1:0] proc_order [NUM_PROCS];

  always #10 clk_i = ~clk_i;

  counting_semaphore_table_core #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .NUM_PROCS     (NUM_PROCS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  csem_checker #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES),
    .NUM_PROCS     (NUM_PROCS)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] rand_val();
    return VAL_W'($urandom());
  endfunction

  function automatic logic [PROC_W-1:0] rand_pid();
    return PROC_W'($urandom());
  endfunction

  function automatic bit in_pool(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < NUM_SEMAPHORES; i++) begin
      if (key_pool[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [KEY_W-1:0] missing_key();
    logic [KEY_W-1:0] k;
    do k = KEY_W'($urandom()); while (in_pool(k));
    return k;
  endfunction

  // one request, with a random idle gap ahead of it; returns once it is taken
  task automatic issue(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                       input logic [PROC_W-1:0] pid, input logic signed [VAL_W-1:0] lim,
                       input logic signed [VAL_W-1:0] cnt);
    req_t r;
    r.func       = func;
    r.sem_key    = key;
    r.proc_id    = pid;
    r.init_limit = lim;
    r.init_count = cnt;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  initial begin
    int          i;
    int          j;
    int          n;
    int unsigned target;
    logic [KEY_W-1:0]        k;
    logic signed [VAL_W-1:0] lim;
    logic [PROC_W-1:0]       tmp;

    key_pool[0] = 8'h00;
    key_pool[1] = 8'hFF;
    for (i = 2; i < NUM_SEMAPHORES; i++) key_pool[i] = 8'h00;
    for (i = 2; i < NUM_SEMAPHORES; i++) key_pool[i] = missing_key();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, extremes, wrap-around, double queueing, full table
    issue(OP_NONE, 8'hFF, '1, -16'sd1, -16'sd1);
    issue(FUNC_WAIT, key_pool[0], 5'd0, '0, '0);
    issue(FUNC_SIGNAL, key_pool[1], 5'd31, '0, '0);
    issue(FUNC_INIT, key_pool[0], 5'd0, VAL_MIN, VAL_MIN + 16'sd1);
    issue(FUNC_INIT, key_pool[0], 5'd0, VAL_MAX, VAL_MAX);
    issue(FUNC_WAIT, key_pool[0], 5'd31, '0, '0);
    issue(FUNC_WAIT, key_pool[0], 5'd31, '0, '0);
    issue(FUNC_INIT, key_pool[1], 5'd0, VAL_MAX, VAL_MAX);
    issue(FUNC_SIGNAL, key_pool[1], 5'd0, '0, '0);
    issue(FUNC_WAIT, key_pool[1], 5'd5, '0, '0);
    issue(FUNC_WAIT, key_pool[1], 5'd5, '0, '0);
    issue(FUNC_WAIT, key_pool[1], 5'd0, '0, '0);
    issue(FUNC_SIGNAL, key_pool[1], 5'd0, '0, '0);
    issue(FUNC_SIGNAL, key_pool[1], 5'd0, '0, '0);
    issue(FUNC_SIGNAL, key_pool[0], 5'd0, '0, '0);
    for (i = 2; i < NUM_SEMAPHORES; i++) begin
      lim = rand_val();
      issue(FUNC_INIT, key_pool[i], rand_pid(), lim, lim + VAL_W'($urandom_range(3)));
    end
    issue(FUNC_INIT, missing_key(), rand_pid(), rand_val(), rand_val());
    issue(FUNC_WAIT, missing_key(), rand_pid(), rand_val(), rand_val());

    // every process queued once on the always-blocking entry so that each link
    // is written before any later queue can follow it
    for (i = 0; i < NUM_PROCS; i++) proc_order[i] = PROC_W'(i);
    for (i = NUM_PROCS - 1; i > 0; i--) begin
      j             = $urandom_range(i);
      tmp           = proc_order[i];
      proc_order[i] = proc_order[j];
      proc_order[j] = tmp;
    end
    for (i = 0; i < NUM_PROCS; i++) begin
      issue(FUNC_WAIT, key_pool[1], proc_order[i], rand_val(), rand_val());
    end
    issue(FUNC_WAIT, key_pool[1], proc_order[0], rand_val(), rand_val());

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      idle_pct = (sent >= 250 && sent < 400) ? 0 : 8;
      if ($urandom_range(99) < 70) begin
        // burst of waits then roughly as many signals on one semaphore
        k = key_pool[$urandom_range(NUM_SEMAPHORES - 1)];
        n = $urandom_range(1, 6);
        repeat (n) issue(FUNC_WAIT, k, rand_pid(), rand_val(), rand_val());
        repeat ($urandom_range(n - 1, n + 1)) begin
          issue(FUNC_SIGNAL, k, rand_pid(), rand_val(), rand_val());
        end
      end else begin
        case ($urandom_range(4))
          0: begin
            k = $urandom_range(1) ? key_pool[$urandom_range(NUM_SEMAPHORES - 1)]
                                  : missing_key();
            issue(FUNC_INIT, k, rand_pid(), rand_val(), rand_val());
          end
          1: issue($urandom_range(1) ? FUNC_WAIT : FUNC_SIGNAL, missing_key(), rand_pid(),
                   rand_val(), rand_val());
          2: issue(OP_NONE, KEY_W'($urandom()), rand_pid(), rand_val(), rand_val());
          default: issue($urandom_range(1) ? FUNC_WAIT : FUNC_SIGNAL,
                         key_pool[$urandom_range(NUM_SEMAPHORES - 1)], rand_pid(),
                         rand_val(), rand_val());
        endcase
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/csem_pkg.sv
rtl/csem_front.sv
rtl/csem_queue.sv
rtl/csem_back.sv
rtl/counting_semaphore_table_core.sv
test/csem_checker.sv
test/tb_counting_semaphore_table_core.sv
